// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the timed gesture gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define GTG_ASSERT_SAME(label, clk, rst, cond, expect_now) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
      else $error("gtg assertion failed: same-cycle implication");

// Check that a condition implies another in the following cycle.
`define GTG_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
      else $error("gtg assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/gtg_pkg.sv =====
// Shared widths, constants and types of the timed gesture gate.
package gtg_pkg;

   localparam int LEVEL_W     = 16;
   localparam int TICK_W      = 32;
   localparam int SPAN_W      = 31;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 24;

   // 1.0 in the 4.12 level format; a level at or above it counts as active
   localparam logic signed [LEVEL_W-1:0] ONE_LEVEL = 16'sd4096;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_PRESENT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODIFIER_PRESENT = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAG_TICKS        = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS       = 8'd3;

   typedef struct packed {
      logic              trigger_present;
      logic              modifier_present;
      logic [SPAN_W-1:0] lag_ticks;
      logic [SPAN_W-1:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] gated_level;
      logic                      is_latched;
      logic                      is_blocked;
   } result_type;

endpackage

// ===== hw/rtl/gtg_csr.sv =====
// Configuration register file of the timed gesture gate.
module gtg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [gtg_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]     wr_data,
   output gtg_pkg::cfg_type                   cfg
);

   gtg_pkg::cfg_type cfg_ff;
   gtg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            gtg_pkg::CSR_TRIGGER_PRESENT:  cfg_in.trigger_present  = wr_data[0];
            gtg_pkg::CSR_MODIFIER_PRESENT: cfg_in.modifier_present = wr_data[0];
            gtg_pkg::CSR_LAG_TICKS:        cfg_in.lag_ticks  = wr_data[gtg_pkg::SPAN_W-1:0];
            gtg_pkg::CSR_HOLD_TICKS:       cfg_in.hold_ticks = wr_data[gtg_pkg::SPAN_W-1:0];
            default:                       cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/gtg_core.sv =====
// Gate state registers and the per-sample decision logic.
module gtg_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  gtg_pkg::cfg_type                     cfg,
   input  logic signed [gtg_pkg::LEVEL_W-1:0]   trigger_level,
   input  logic signed [gtg_pkg::LEVEL_W-1:0]   modifier_level,
   input  logic [gtg_pkg::TICK_W-1:0]           now_ticks,
   output gtg_pkg::result_type                  result
);

   logic                        trig_was_ff, trig_was_in;
   logic [gtg_pkg::TICK_W-1:0]  trig_rise_ff, trig_rise_in;
   logic                        mod_was_ff, mod_was_in;
   logic [gtg_pkg::TICK_W-1:0]  mod_rise_ff, mod_rise_in;
   logic                        latched_ff, latched_in;
   logic                        blocked_ff, blocked_in;
   logic                        qualifying_ff, qualifying_in;
   logic [gtg_pkg::TICK_W-1:0]  qual_start_ff, qual_start_in;

   logic                        trig_act;
   logic                        mod_act;
   logic                        pass;
   logic [gtg_pkg::TICK_W-1:0]  lag_ext;
   logic [gtg_pkg::TICK_W-1:0]  hold_ext;
   logic [gtg_pkg::TICK_W-1:0]  trig_elapsed;
   logic [gtg_pkg::TICK_W-1:0]  rise_diff;
   logic                        mod_first;
   logic [gtg_pkg::TICK_W-1:0]  qual_elapsed;

   // Clamping the modifier to 0..1.0 does not change whether it reaches 1.0
   assign trig_act = (trigger_level >= gtg_pkg::ONE_LEVEL);
   assign mod_act  = (modifier_level >= gtg_pkg::ONE_LEVEL);
   assign lag_ext  = {1'b0, cfg.lag_ticks};
   assign hold_ext = {1'b0, cfg.hold_ticks};

   always_comb begin
      trig_was_in   = trig_was_ff;
      trig_rise_in  = trig_rise_ff;
      mod_was_in    = mod_was_ff;
      mod_rise_in   = mod_rise_ff;
      latched_in    = latched_ff;
      blocked_in    = blocked_ff;
      qualifying_in = qualifying_ff;
      qual_start_in = qual_start_ff;
      pass          = 1'b0;
      trig_elapsed  = '0;
      rise_diff     = '0;
      mod_first     = 1'b0;
      qual_elapsed  = '0;

      if (!cfg.trigger_present) begin
         pass = 1'b0;
      end else if (!cfg.modifier_present) begin
         pass = 1'b1;
      end else begin
         // Track edges of both levels
         if (trig_act) begin
            if (!trig_was_ff) begin
               trig_rise_in = now_ticks;
            end
            trig_was_in = 1'b1;
         end else begin
            latched_in    = 1'b0;
            blocked_in    = 1'b0;
            trig_was_in   = 1'b0;
            qualifying_in = 1'b0;
         end
         if (mod_act) begin
            if (!mod_was_ff) begin
               mod_rise_in = now_ticks;
            end
            mod_was_in = 1'b1;
         end else begin
            mod_was_in    = 1'b0;
            qualifying_in = 1'b0;
         end

         trig_elapsed = now_ticks - trig_rise_in;
         rise_diff    = mod_rise_in - trig_rise_in;
         mod_first    = (rise_diff == '0) || rise_diff[gtg_pkg::TICK_W-1];

         priority if (latched_in) begin
            pass = 1'b1;
         end else if (blocked_in) begin
            pass = 1'b0;
         end else if (!trig_act) begin
            pass = mod_act;
         end else if (!mod_act) begin
            // Modifier still missing: block once the lag runs out
            if (trig_elapsed > lag_ext) begin
               blocked_in = 1'b1;
            end
            pass = 1'b0;
         end else if (!mod_first && (rise_diff > lag_ext)) begin
            blocked_in = 1'b1;
            pass       = 1'b0;
         end else begin
            if (!qualifying_in) begin
               qual_start_in = now_ticks;
               qualifying_in = 1'b1;
            end
            qual_elapsed = now_ticks - qual_start_in;
            if (qual_elapsed < hold_ext) begin
               pass = 1'b0;
            end else begin
               latched_in = 1'b1;
               pass       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_was_ff   <= 1'b0;
         trig_rise_ff  <= '0;
         mod_was_ff    <= 1'b0;
         mod_rise_ff   <= '0;
         latched_ff    <= 1'b0;
         blocked_ff    <= 1'b0;
         qualifying_ff <= 1'b0;
         qual_start_ff <= '0;
      end else if (enable) begin
         trig_was_ff   <= trig_was_in;
         trig_rise_ff  <= trig_rise_in;
         mod_was_ff    <= mod_was_in;
         mod_rise_ff   <= mod_rise_in;
         latched_ff    <= latched_in;
         blocked_ff    <= blocked_in;
         qualifying_ff <= qualifying_in;
         qual_start_ff <= qual_start_in;
      end
   end

   assign result.gated_level = pass ? trigger_level : '0;
   assign result.is_latched  = latched_in;
   assign result.is_blocked  = blocked_in;

endmodule

// ===== hw/rtl/timed_gesture_gate_top.sv =====
// Top level of the timed gesture gate: stream ports, sample and result registers.
//
// The timed gesture gate takes one timestamped sample per req beat (trigger level,
// modifier level, both signed 4.12 with 4096 = 1.0, and a 32-bit wrapping tick count)
// and returns exactly one rsp beat per sample: the trigger level when the gate passes
// it, else zero, plus the latched and blocked flags after that sample. The gate opens
// when the modifier reached 1.0 no later than lag_ticks after the trigger did, stays
// qualifying while both are held for hold_ticks, then latches until the trigger falls;
// a missed lag blocks the output until the trigger is released. A sample goes through
// two registers: the req beat lands in the sample register, the decision and the gate
// state update are made from it when the pipe advances and the result lands in the rsp
// register, and the block takes one sample every cycle as long as rsp beats are taken.
// The rate is set by the state update in gtg_core, which each sample must see from the
// one before. With trigger_present clear the output is zero; with modifier_present clear
// the trigger passes straight through; in both cases the gate state holds. Configuration
// beats on the csr channel are always accepted and should be sent only while no sample
// is in flight.
module timed_gesture_gate_top (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: trigger_level[15:0], modifier_level[31:16], now_ticks[63:32]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gtg_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: gated_level[15:0], is_latched[16], is_blocked[17], zero fill[23:18]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gtg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gtg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

`include "assert_macros.svh"

   gtg_pkg::cfg_type                     cfg;
   gtg_pkg::result_type                  core_result;

   logic                                 in_valid_ff, in_valid_in;
   logic signed [gtg_pkg::LEVEL_W-1:0]   trig_ff, trig_in;
   logic signed [gtg_pkg::LEVEL_W-1:0]   mod_ff, mod_in;
   logic [gtg_pkg::TICK_W-1:0]           now_ff, now_in;
   logic                                 out_valid_ff, out_valid_in;
   gtg_pkg::result_type                  out_result_ff, out_result_in;

   logic                                 advance;
   logic                                 req_beat;

   // The result register drains or is empty: the whole pipe moves
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance || !in_valid_ff;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   gtg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   gtg_core u_core (
      .clock          (clock),
      .reset          (reset),
      .enable         (in_valid_ff && advance),
      .cfg            (cfg),
      .trigger_level  (trig_ff),
      .modifier_level (mod_ff),
      .now_ticks      (now_ff),
      .result         (core_result)
   );

   always_comb begin
      // Sample register: load on a req beat, empty when its sample moves on
      in_valid_in = in_valid_ff;
      trig_in     = trig_ff;
      mod_in      = mod_ff;
      now_in      = now_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
         trig_in     = req_tdata[15:0];
         mod_in      = req_tdata[31:16];
         now_in      = req_tdata[63:32];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // Result register: advance with the pipe, hold while rsp stalls
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (advance) begin
         out_valid_in  = in_valid_ff;
         out_result_in = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      trig_ff       <= trig_in;
      mod_ff        <= mod_in;
      now_ff        <= now_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_result_ff.is_blocked, out_result_ff.is_latched,
                        out_result_ff.gated_level};

   // The gate is never latched and blocked at once
   `GTG_ASSERT_SAME(a_latch_block_excl, clock, reset, rsp_tvalid, !(rsp_tdata[16] && rsp_tdata[17]))
   // A req beat during an rsp stall may only fill an empty sample register
   `GTG_ASSERT_SAME(a_stall_fill_empty, clock, reset, req_beat && rsp_tvalid && !rsp_tready, !in_valid_ff)
   // A waiting sample is not dropped while the pipe is stalled
   `GTG_ASSERT_NEXT(a_stall_keeps_sample, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
